/* design/ook_pulse_width_code_decoder_assert.svh */
// assertion macros for the ook pulse-width code decoder
// used by the top level only, no other dependencies
`ifndef OOK_PULSE_WIDTH_CODE_DECODER_ASSERT_SVH
`define OOK_PULSE_WIDTH_CODE_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OPCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("opcd check failed");

// next-cycle implication, checked out of reset
`define OPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("opcd check failed");

`endif

/* design/opcd_pkg.sv */
// shared types and constants of the ook pulse-width code decoder
// no dependencies
`timescale 1ns / 1ps

package opcd_pkg;

    localparam int CODE_BITS_DEF = 24;
    localparam int MAX_ITEMS_DEF = 2048;

    localparam int DUR_W       = 32;
    localparam int SYNC_GAP_W  = 20;
    localparam int LONG_PULS_W = 16;
    localparam int MIN_ITEMS_W = 12;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [SYNC_GAP_W-1:0]  SYNC_GAP_RST  = SYNC_GAP_W'(8000);
    localparam logic [LONG_PULS_W-1:0] LONG_PULS_RST = LONG_PULS_W'(600);
    localparam logic [MIN_ITEMS_W-1:0] MIN_ITEMS_RST = MIN_ITEMS_W'(10);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_GAP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PULSE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_ITEMS  = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_CODE    = 2'd1,
        VERDICT_UNKNOWN = 2'd2
    } verdict_t;

endpackage

/* design/opcd_in_if.sv */
// input channel of the decoder: one signed duration per item
// depends on opcd_pkg
`timescale 1ns / 1ps

interface opcd_in_if;
    import opcd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [DUR_W-1:0] duration;
    logic                    last;

    modport source (output valid, output duration, output last, input ready);
    modport sink (input valid, input duration, input last, output ready);
endinterface

/* design/opcd_out_if.sv */
// output channel of the decoder: one verdict per signal
// depends on opcd_pkg
`timescale 1ns / 1ps

interface opcd_out_if #(
    parameter int CODE_W  = opcd_pkg::CODE_BITS_DEF,
    parameter int TOTAL_W = $clog2(opcd_pkg::MAX_ITEMS_DEF + 1)
);
    import opcd_pkg::*;

    logic               valid;
    logic               ready;
    verdict_t           verdict;
    logic [CODE_W-1:0]  code;
    logic [TOTAL_W-1:0] item_total;

    modport source (output valid, output verdict, output code, output item_total,
                    input ready);
    modport sink (input valid, input verdict, input code, input item_total,
                  output ready);
endinterface

/* design/ook_pulse_width_code_decoder.sv */
// ook pulse-width code decoder, top level
// depends on opcd_pkg, opcd_in_if, opcd_out_if and the assertion macro header
//
//  channel   dir  payload                              handshake
//  --------  ---  -----------------------------------  -------------------
//  in_ch     in   duration (s32), last                 valid/ready
//  out_ch    out  verdict (2), code, item_total        valid/ready
//  cfg       in   cfg_addr (2), cfg_data (20)          cfg_wen, no stall
//
// one item per cycle unless a stalled result holds back a last item; an item waits in
// the input register while the decode logic works on it, and when it advances the decode
// state is updated and, on a last item, the result register is loaded, so a verdict is
// offered from the result register, which follows the input register.
// rst_n clears all control state and loads the default thresholds.
// a stalled result only holds back a last item; other items keep flowing.
`timescale 1ns / 1ps
`include "ook_pulse_width_code_decoder_assert.svh"

module ook_pulse_width_code_decoder #(
    parameter int CODE_BITS = opcd_pkg::CODE_BITS_DEF,
    parameter int MAX_ITEMS = opcd_pkg::MAX_ITEMS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [opcd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [opcd_pkg::CFG_DATA_W-1:0]   cfg_data,
    opcd_in_if.sink                           in_ch,
    opcd_out_if.source                        out_ch
);
    import opcd_pkg::*;

    // counter holds MAX_ITEMS itself, bit counter holds CODE_BITS itself
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int BITS_W = $clog2(CODE_BITS + 1);
    localparam int CMP_W  = (CNT_W > MIN_ITEMS_W) ? CNT_W : MIN_ITEMS_W;
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_ITEMS);
    localparam logic [BITS_W-1:0] BITS_FULL = BITS_W'(CODE_BITS);

    // configuration registers
    logic [SYNC_GAP_W-1:0]  sync_gap_reg;
    logic [LONG_PULS_W-1:0] long_pulse_reg;
    logic [MIN_ITEMS_W-1:0] min_items_reg;

    // input register
    logic                    in_valid_reg;
    logic signed [DUR_W-1:0] in_dur_reg;
    logic                    in_last_reg;

    // per-signal decode state
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 sync_reg, sync_next;
    logic [BITS_W-1:0]    bits_reg, bits_next;
    logic                 half_reg, half_next;
    logic                 long_reg, long_next;
    logic [CODE_BITS-1:0] code_reg, code_next;

    // result register
    logic                 res_valid_reg, res_valid_next;
    verdict_t             res_verdict_reg, res_verdict_next;
    logic [CODE_BITS-1:0] res_code_reg, res_code_next;
    logic [CNT_W-1:0]     res_total_reg;

    // decode datapath
    logic              advance;
    logic              take_in;
    logic              negative;
    logic [DUR_W-1:0]  gap_len;
    logic              long_gap;
    logic              long_mark;
    logic              first_item;
    logic [CNT_W-1:0]  cnt_inc;

    // the state stage moves unless it holds a last item and the result is stuck
    assign advance = in_valid_reg && (!in_last_reg || !res_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign take_in = in_ch.valid && in_ch.ready;

    // magnitude of a gap; the most negative value maps to 2^31 as unsigned
    assign negative  = in_dur_reg[DUR_W-1];
    assign gap_len   = (~in_dur_reg) + DUR_W'(1);
    assign long_gap  = negative && (gap_len > DUR_W'(sync_gap_reg));
    assign long_mark = !negative && (in_dur_reg[DUR_W-2:0] > (DUR_W-1)'(long_pulse_reg));

    assign first_item = (cnt_reg == '0);
    assign cnt_inc    = (cnt_reg < CNT_MAX) ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_comb
    begin
        sync_next = sync_reg;
        bits_next = bits_reg;
        half_next = half_reg;
        long_next = long_reg;
        code_next = code_reg;

        // hunt for sync, then alternate mark and gap until the code is full
        if (!sync_reg)
        begin
            if (!first_item && long_gap)
                sync_next = 1'b1;
        end
        else if (bits_reg < BITS_FULL)
        begin
            if (!half_reg)
            begin
                long_next = long_mark;
                half_next = 1'b1;
            end
            else
            begin
                code_next = CODE_BITS'({code_reg, long_reg && negative});
                bits_next = bits_reg + BITS_W'(1);
                half_next = 1'b0;
            end
        end

        // verdict on the updated state
        res_code_next = '0;
        if (CMP_W'(cnt_inc) < CMP_W'(min_items_reg))
            res_verdict_next = VERDICT_NONE;
        else if (sync_next && (bits_next >= BITS_FULL))
        begin
            res_verdict_next = VERDICT_CODE;
            res_code_next    = code_next;
        end
        else
            res_verdict_next = VERDICT_UNKNOWN;

        cnt_next = cnt_inc;

        // a last item closes the signal
        if (in_last_reg)
        begin
            cnt_next  = '0;
            sync_next = 1'b0;
            bits_next = '0;
            half_next = 1'b0;
            long_next = 1'b0;
            code_next = '0;
        end

        res_valid_next = (advance && in_last_reg) || (res_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_gap_reg    <= SYNC_GAP_RST;
            long_pulse_reg  <= LONG_PULS_RST;
            min_items_reg   <= MIN_ITEMS_RST;
            in_valid_reg    <= 1'b0;
            cnt_reg         <= '0;
            sync_reg        <= 1'b0;
            bits_reg        <= '0;
            half_reg        <= 1'b0;
            long_reg        <= 1'b0;
            code_reg        <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_addr)
                    REG_SYNC_GAP:   sync_gap_reg   <= cfg_data[SYNC_GAP_W-1:0];
                    REG_LONG_PULSE: long_pulse_reg <= cfg_data[LONG_PULS_W-1:0];
                    REG_MIN_ITEMS:  min_items_reg  <= cfg_data[MIN_ITEMS_W-1:0];
                    default:        ;
                endcase
            end

            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                cnt_reg  <= cnt_next;
                sync_reg <= sync_next;
                bits_reg <= bits_next;
                half_reg <= half_next;
                long_reg <= long_next;
                code_reg <= code_next;
            end

            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_dur_reg  <= in_ch.duration;
            in_last_reg <= in_ch.last;
        end
        if (advance && in_last_reg)
        begin
            res_verdict_reg <= res_verdict_next;
            res_code_reg    <= res_code_next;
            res_total_reg   <= cnt_inc;
        end
    end

    assign out_ch.valid      = res_valid_reg;
    assign out_ch.verdict    = res_verdict_reg;
    assign out_ch.code       = res_code_reg;
    assign out_ch.item_total = res_total_reg;

    // code field is zero unless a code was decoded
    `OPCD_ASSERT_NOW(a_code_zero, clk, rst_n,
        res_valid_reg && (res_verdict_reg != VERDICT_CODE), res_code_reg == '0)
    // closing a signal clears the per-signal state
    `OPCD_ASSERT_NEXT(a_clear_on_last, clk, rst_n,
        advance && in_last_reg, (cnt_reg == '0) && !sync_reg && (bits_reg == '0))
    // the bit counter never runs past the code length
    `OPCD_ASSERT_NOW(a_bits_bound, clk, rst_n, 1'b1, bits_reg <= BITS_FULL)
    // pairs are only decoded after sync
    `OPCD_ASSERT_NOW(a_pairs_need_sync, clk, rst_n,
        (bits_reg != '0) || half_reg, sync_reg)

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the ook pulse-width code decoder
// depends on opcd_pkg, opcd_in_if, opcd_out_if and the decoder top level
`timescale 1ns / 1ps

module tb_top;
    import opcd_pkg::*;

    localparam int CODE_BITS    = CODE_BITS_DEF;
    localparam int MAX_ITEMS    = MAX_ITEMS_DEF;
    localparam int TOTAL_W      = $clog2(MAX_ITEMS + 1);
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 650;

    // index that maps to no register, writes to it must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        verdict_t             verdict;
        logic [CODE_BITS-1:0] code;
        logic [TOTAL_W-1:0]   item_total;
    } verdict_rec_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_wen;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    opcd_in_if  in_ch ();
    opcd_out_if out_ch ();

    ook_pulse_width_code_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // shared testbench state
    // ------------------------------------------------------------------
    verdict_rec_t            pending_verdicts[$];  // verdicts still to come out
    logic signed [DUR_W-1:0] burst[$];             // durations of the next signal
    int                      error_count = 0;
    int                      cycle_count = 0;
    int                      hold_left   = 0;      // long receiver hold-off, in cycles
    bit                      tx_quiet    = 1'b0;   // sender offers back to back
    bit                      rx_quiet    = 1'b0;   // receiver takes no random stalls

    // mirror of the threshold registers
    logic [SYNC_GAP_W-1:0]   sync_gap_r;
    logic [LONG_PULS_W-1:0]  long_pulse_r;
    logic [MIN_ITEMS_W-1:0]  min_items_r;

    // mirror of the per-signal decode state
    int                      seen_count;
    bit                      sync_found;
    int                      pairs_done;
    bit                      in_gap;
    bit                      mark_long;
    logic [CODE_BITS-1:0]    code_acc;

    // ------------------------------------------------------------------
    // decode predictor
    // ------------------------------------------------------------------
    function automatic void clear_track();
        seen_count = 0;
        sync_found = 1'b0;
        pairs_done = 0;
        in_gap     = 1'b0;
        mark_long  = 1'b0;
        code_acc   = '0;
    endfunction

    // advances the mirrored state by one duration, returns 1 when a verdict is due
    function automatic bit decode_step(input logic signed [DUR_W-1:0] dur,
                                       input bit is_last, output verdict_rec_t rec);
        bit     neg;
        bit     first;
        longint mag;
        rec   = '0;
        neg   = dur[DUR_W-1];
        // 64-bit magnitude so the most negative duration stays exact
        mag   = neg ? -longint'(dur) : 64'sd0;
        first = (seen_count == 0);
        if (seen_count < MAX_ITEMS)
            seen_count++;

        if (!sync_found)
        begin
            // a long gap as the very first item never counts as sync
            if (!first && neg && mag > longint'(sync_gap_r))
                sync_found = 1'b1;
        end
        else if (pairs_done < CODE_BITS)
        begin
            if (!in_gap)
            begin
                mark_long = !neg && (longint'(dur) > longint'(long_pulse_r));
                in_gap    = 1'b1;
            end
            else
            begin
                // bit is 1 only for a long mark followed by a real gap
                code_acc   = {code_acc[CODE_BITS-2:0], mark_long && neg};
                pairs_done++;
                in_gap     = 1'b0;
            end
        end
        // items after the last pair are only counted

        if (!is_last)
            return 1'b0;

        rec.item_total = TOTAL_W'(seen_count);
        if (seen_count < int'(min_items_r))
        begin
            // too few items wins over everything else
            rec.verdict = VERDICT_NONE;
            rec.code    = '0;
        end
        else if (sync_found && pairs_done >= CODE_BITS)
        begin
            rec.verdict = VERDICT_CODE;
            rec.code    = code_acc;
        end
        else
        begin
            rec.verdict = VERDICT_UNKNOWN;
            rec.code    = '0;
        end
        clear_track();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // duration generators, aimed at the current thresholds
    // ------------------------------------------------------------------
    function automatic logic signed [DUR_W-1:0] short_mark();
        return DUR_W'($urandom_range(long_pulse_r, 0));
    endfunction

    function automatic logic signed [DUR_W-1:0] long_mark();
        return DUR_W'(int'(long_pulse_r) + 1 + $urandom_range(2000, 0));
    endfunction

    function automatic logic signed [DUR_W-1:0] short_gap();
        logic signed [DUR_W-1:0] m;
        m = DUR_W'($urandom_range(sync_gap_r, 1));
        return -m;
    endfunction

    function automatic logic signed [DUR_W-1:0] sync_item();
        logic signed [DUR_W-1:0] m;
        m = DUR_W'(int'(sync_gap_r) + 1 + $urandom_range(5000, 0));
        return -m;
    endfunction

    function automatic logic signed [DUR_W-1:0] pair_gap();
        logic signed [DUR_W-1:0] m;
        m = DUR_W'($urandom_range(3000, 1));
        return -m;
    endfunction

    // alternating short marks and short gaps, starting with a mark
    function automatic void add_preamble(input int n);
        for (int i = 0; i < n; i++)
            burst.push_back((i % 2 == 0) ? short_mark() : short_gap());
    endfunction

    // n items of mark/gap pairs carrying code msb first, some pairs broken on request
    function automatic void add_pairs(input logic [CODE_BITS-1:0] code, input int n_items,
                                      input int corrupt_pct);
        logic signed [DUR_W-1:0] d;
        int                      idx;
        for (int k = 0; k < n_items; k++)
        begin
            idx = CODE_BITS - 1 - k / 2;
            if (k % 2 == 0)
            begin
                d = (idx >= 0 && code[idx]) ? long_mark() : short_mark();
                if ($urandom_range(99, 0) < corrupt_pct)
                    d = -long_mark();                       // mark turned into a gap
            end
            else
            begin
                d = pair_gap();
                if ($urandom_range(99, 0) < corrupt_pct)
                    d = DUR_W'($urandom_range(3000, 0));    // gap turned into a mark
            end
            burst.push_back(d);
        end
    endfunction

    // preamble, sync gap and a complete code
    function automatic void add_frame(input logic [CODE_BITS-1:0] code, input int corrupt_pct);
        add_preamble($urandom_range(4, 1));
        burst.push_back(sync_item());
        add_pairs(code, 2 * CODE_BITS, corrupt_pct);
    endfunction

    // mostly well-formed signals with random content, the rest broken or noise
    function automatic void build_random_signal();
        int kind;
        kind = $urandom_range(99, 0);
        if (kind < 60)
        begin
            if ($urandom_range(9, 0) == 0)
                burst.push_back(sync_item());               // long gap on the first item
            add_frame(CODE_BITS'($urandom), 5);
            repeat ($urandom_range(3, 0))
            begin
                case ($urandom_range(2, 0))
                    0:       burst.push_back(sync_item());
                    1:       burst.push_back(long_mark());
                    default: burst.push_back(pair_gap());
                endcase
            end
        end
        else if (kind < 72)
        begin
            // code cut short, possibly in the middle of a pair
            add_preamble($urandom_range(4, 1));
            burst.push_back(sync_item());
            add_pairs(CODE_BITS'($urandom), $urandom_range(2 * CODE_BITS - 1, 0), 5);
        end
        else if (kind < 80)
            add_preamble($urandom_range(30, 10));
        else if (kind < 92)
        begin
            repeat ($urandom_range(30, 1))
                burst.push_back(DUR_W'($urandom));
        end
        else
            add_preamble($urandom_range(12, 1));
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    // offers one item after a random gap, returns right after it is accepted;
    // valid stays high so a following item with no gap needs no second assignment
    task automatic send_item(input logic signed [DUR_W-1:0] dur, input bit is_last);
        int           idle;
        verdict_rec_t rec;
        idle = tx_quiet ? 0 : $urandom_range(10, 0);
        if (idle > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.duration <= dur;
        in_ch.last     <= is_last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (decode_step(dur, is_last, rec))
            pending_verdicts.push_back(rec);
    endtask

    // sends the built signal with last on its final duration
    task automatic send_burst();
        for (int i = 0; i < burst.size(); i++)
            send_item(burst[i], i == burst.size() - 1);
        burst.delete();
    endtask

    // stops offering, waits for every verdict and lets the pipeline settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    // leaves cfg_wen high so back to back writes need one assignment per edge
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wen  <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_SYNC_GAP:   sync_gap_r   = value[SYNC_GAP_W-1:0];
            REG_LONG_PULSE: long_pulse_r = value[LONG_PULS_W-1:0];
            REG_MIN_ITEMS:  min_items_r  = value[MIN_ITEMS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input int sync_gap, input int long_pulse, input int min_cnt);
        wait_idle();
        write_reg(REG_SYNC_GAP, CFG_DATA_W'(sync_gap));
        write_reg(REG_LONG_PULSE, CFG_DATA_W'(long_pulse));
        write_reg(REG_MIN_ITEMS, CFG_DATA_W'(min_cnt));
        cfg_wen <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stall after each verdict, plus the long hold-off
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                stall_left = rx_quiet ? 0 : $urandom_range(10, 0);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checker, compares each verdict with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_verdict
        verdict_rec_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict with none expected: verdict %0d code %06h total %0d",
                       out_ch.verdict, out_ch.code, out_ch.item_total);
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (out_ch.verdict !== want.verdict)
                begin
                    $error("verdict mismatch: expected %0d, got %0d",
                           want.verdict, out_ch.verdict);
                    error_count++;
                end
                if (out_ch.code !== want.code)
                begin
                    $error("code mismatch: expected %06h, got %06h", want.code, out_ch.code);
                    error_count++;
                end
                if (out_ch.item_total !== want.item_total)
                begin
                    $error("item_total mismatch: expected %0d, got %0d",
                           want.item_total, out_ch.item_total);
                    error_count++;
                end
            end
        end
    end

    // cycle counter and watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= LIMIT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset thresholds, duration extremes and all-ones / all-zeros codes
    task automatic test_defaults();
        // widest mark first, zero-length mark, most negative duration as sync
        burst.push_back(DUR_W'(32'h7FFF_FFFF));
        burst.push_back(short_gap());
        burst.push_back(DUR_W'(0));
        burst.push_back(DUR_W'(32'h8000_0000));
        add_pairs(24'hA5F00F, 2 * CODE_BITS, 0);
        send_burst();

        // trailing items after a full code, including a new sync, change nothing
        add_frame({CODE_BITS{1'b1}}, 0);
        burst.push_back(sync_item());
        burst.push_back(long_mark());
        add_pairs('0, 10, 0);
        send_burst();

        add_frame('0, 0);
        send_burst();
    endtask

    task automatic test_special_cases();
        // fewer items than the minimum
        add_preamble(9);
        send_burst();

        // one item that is also the last
        burst.push_back(long_mark());
        send_burst();

        // long gap on the first item only, so no sync at all
        burst.push_back(sync_item());
        add_pairs(CODE_BITS'($urandom), 2 * CODE_BITS, 0);
        send_burst();

        // sync found on the last item, no pairs follow
        add_preamble(12);
        burst.push_back(sync_item());
        send_burst();

        // code one item short
        add_preamble(2);
        burst.push_back(sync_item());
        add_pairs(CODE_BITS'($urandom), 2 * CODE_BITS - 1, 0);
        send_burst();

        // no sync gap anywhere
        add_preamble(20);
        send_burst();

        // negative mark, then long mark with a positive gap: both pairs give 0
        add_preamble(2);
        burst.push_back(sync_item());
        burst.push_back(-long_mark());
        burst.push_back(pair_gap());
        burst.push_back(long_mark());
        burst.push_back(DUR_W'(500));
        add_pairs({CODE_BITS{1'b1}}, 2 * CODE_BITS - 4, 0);
        send_burst();
    endtask

    task automatic test_config_extremes();
        // all thresholds at zero: every negative after the first item counts as sync, every nonzero mark is long
        apply_config(0, 0, 0);
        add_frame(CODE_BITS'($urandom), 0);
        send_burst();
        burst.push_back(short_mark());
        send_burst();

        // sync gap and long pulse at the top of their range, minimum of one item
        apply_config(1048575, 65535, 1);
        add_frame(CODE_BITS'($urandom), 0);
        send_burst();
        add_preamble(6);
        send_burst();

        // bits above the register width dropped, spare index ignored
        wait_idle();
        write_reg(REG_LONG_PULSE, 20'hF0258);
        write_reg(REG_MIN_ITEMS, 20'hFF00C);
        write_reg(REG_SYNC_GAP, 20'd8000);
        write_reg(REG_SPARE, 20'h00001);
        cfg_wen <= 1'b0;
        add_preamble(11);
        send_burst();
        add_frame(CODE_BITS'($urandom), 0);
        send_burst();
    endtask

    // item count saturation with the minimum set to MAX_ITEMS
    task automatic test_saturation();
        apply_config(8000, 600, 2048);
        tx_quiet = 1'b1;
        add_frame(CODE_BITS'($urandom), 0);
        add_preamble(MAX_ITEMS - 1 - burst.size());
        send_burst();
        add_frame(CODE_BITS'($urandom), 0);
        add_preamble(MAX_ITEMS + 52 - burst.size());
        send_burst();
        tx_quiet = 1'b0;
    endtask

    // receiver holds off while short signals keep coming, so the input stalls
    task automatic test_backpressure();
        apply_config(8000, 600, 2);
        hold_left = HOLD_CYCLES;
        tx_quiet  = 1'b1;
        repeat (6)
        begin
            add_preamble(3);
            send_burst();
        end
        add_frame(CODE_BITS'($urandom), 0);
        send_burst();
        tx_quiet = 1'b0;
        wait_idle();
    endtask

    // random signals over several threshold settings
    task automatic test_random();
        int phase_items;
        int phase_signals;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: apply_config(8000, 600, 10);
                1: apply_config(0, 0, 0);
                2: apply_config(1048575, 65535, 1);
                5: apply_config($urandom_range(20000, 200), $urandom_range(3000, 50), 2048);
                default:
                    apply_config($urandom_range(20000, 200), $urandom_range(3000, 50),
                                 $urandom_range(60, 2));
            endcase
            // a stretch without any idling on either side
            tx_quiet      = (phase == 2);
            rx_quiet      = (phase == 2);
            phase_items   = 0;
            phase_signals = 0;
            while ((phase < 5 && (phase_items < RANDOM_ITEMS / 5 || phase_signals < 8))
                   || (phase == 5 && phase_signals < 4))
            begin
                build_random_signal();
                phase_items += burst.size();
                phase_signals++;
                send_burst();
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : run
        in_ch.valid    <= 1'b0;
        in_ch.duration <= '0;
        in_ch.last     <= 1'b0;
        cfg_wen        <= 1'b0;
        cfg_addr       <= REG_SYNC_GAP;
        cfg_data       <= '0;
        sync_gap_r      = SYNC_GAP_RST;
        long_pulse_r    = LONG_PULS_RST;
        min_items_r     = MIN_ITEMS_RST;
        clear_track();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_special_cases();
        test_config_extremes();
        test_saturation();
        test_backpressure();
        test_random();

        // all offered, wait for the last verdicts and a little longer
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/opcd_pkg.sv
design/opcd_in_if.sv
design/opcd_out_if.sv
design/ook_pulse_width_code_decoder.sv
tb/sv/tb_top.sv
